@@ rtl/gfc_pkg.sv @@
// Shared constants for the greedy first-fit node coloring block.
package gfc_pkg;

  // Field widths
  localparam int unsigned NodeW  = 12;
  localparam int unsigned ColorW = 5;

  // Number of colors tracked in the used-color mask; a stored color of this
  // value or above never marks the mask.
  localparam int unsigned MaskColors = 31;

  // Default configuration
  localparam int unsigned MaxNodesDef   = 4096;
  localparam int unsigned ColorLimitDef = 16;

endpackage

@@ rtl/gfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/greedy_first_fit_node_coloring.sv @@
// Greedy first-fit node coloring: color store, used-color mask and color pick.
// The beat that ends a node is registered in stage 1, then loads the output register.
// Throughput: one input beat per cycle unless stalled; the store read is issued at the
// input and its registered data is used one stage later, with the last write forwarded.
// Reset clears the stage, forward and output valids and the used-color mask;
// the color store is not cleared and holds garbage until a node is written.
module greedy_first_fit_node_coloring #(
  parameter int unsigned MaxNodes   = gfc_pkg::MaxNodesDef,
  parameter int unsigned ColorLimit = gfc_pkg::ColorLimitDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gfc_pkg::NodeW-1:0]  node_index_i,
  input  logic [gfc_pkg::NodeW-1:0]  neighbor_index_i,
  input  logic                       neighbor_valid_i,
  input  logic                       last_neighbor_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gfc_pkg::NodeW-1:0]  colored_node_o,
  output logic [gfc_pkg::ColorW-1:0] node_color_o
);

  localparam int unsigned AddrW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned ExtW  = (AddrW > gfc_pkg::NodeW) ? AddrW : gfc_pkg::NodeW;
  localparam int unsigned MaskW = gfc_pkg::MaskColors;
  localparam logic [gfc_pkg::ColorW-1:0] ColorCap = gfc_pkg::ColorW'(ColorLimit - 1);

  // Stage registers
  logic                        s1_valid_q;
  logic [gfc_pkg::NodeW-1:0]   s1_node_q;
  logic [gfc_pkg::NodeW-1:0]   s1_nb_q;
  logic                        s1_nb_valid_q;
  logic                        s1_last_q;
  logic [MaskW-1:0]            mask_q, mask_d;
  logic                        fwd_valid_q;
  logic [AddrW-1:0]            fwd_addr_q;
  logic [gfc_pkg::ColorW-1:0]  fwd_color_q;
  logic                        out_valid_q;
  logic [gfc_pkg::NodeW-1:0]   colored_node_q;
  logic [gfc_pkg::ColorW-1:0]  node_color_q;

  logic                        in_accept;
  logic                        s1_adv;
  logic                        out_load;
  logic [ExtW-1:0]             in_nb_ext;
  logic [ExtW-1:0]             s1_nb_ext;
  logic [ExtW-1:0]             s1_node_ext;
  logic [AddrW-1:0]            rd_addr;
  logic [AddrW-1:0]            s1_nb_addr;
  logic [AddrW-1:0]            s1_node_addr;
  logic [gfc_pkg::ColorW-1:0]  ram_color;
  logic [gfc_pkg::ColorW-1:0]  nb_color;
  logic                        nb_counts;
  logic                        node_in_store;
  logic [MaskW-1:0]            mask_merged;
  logic [gfc_pkg::ColorW-1:0]  chosen;
  logic                        found;
  logic                        store_we;

  // Handshake: stage 1 moves unless a last beat waits on a full output
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = s1_adv && s1_last_q;

  // Address the store from the neighbor index for reads and the node index for writes
  assign in_nb_ext   = ExtW'(neighbor_index_i);
  assign rd_addr     = in_nb_ext[AddrW-1:0];
  assign s1_nb_ext   = ExtW'(s1_nb_q);
  assign s1_nb_addr  = s1_nb_ext[AddrW-1:0];
  assign s1_node_ext = ExtW'(s1_node_q);
  assign s1_node_addr = s1_node_ext[AddrW-1:0];

  gfc_ram #(
    .Width (gfc_pkg::ColorW),
    .Depth (MaxNodes)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s1_node_addr),
    .wdata_i (chosen),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_color)
  );

  // Forward the write that landed with the read
  assign nb_color = (fwd_valid_q && (fwd_addr_q == s1_nb_addr)) ? fwd_color_q : ram_color;

  // Qualify the neighbor and merge its color into the mask
  always_comb begin
    nb_counts = s1_nb_valid_q && (s1_nb_q < s1_node_q)
                && (32'(s1_nb_q) < 32'(MaxNodes))
                && (32'(nb_color) < 32'(MaskW));
    mask_merged = mask_q;
    if (nb_counts) begin
      mask_merged = mask_q | (MaskW'(1) << nb_color);
    end
  end

  // Pick the lowest free color below the cap, else the cap itself
  always_comb begin
    chosen = ColorCap;
    found  = 1'b0;
    for (int i = 0; i < MaskW; i++) begin
      if (!found && (i < int'(ColorCap)) && !mask_merged[i]) begin
        chosen = gfc_pkg::ColorW'(i);
        found  = 1'b1;
      end
    end
  end

  assign node_in_store = 32'(s1_node_q) < 32'(MaxNodes);
  assign store_we      = out_load && node_in_store;

  // Next mask: merge each advancing beat, clear after a node's last beat
  always_comb begin
    mask_d = mask_q;
    if (s1_adv) begin
      mask_d = s1_last_q ? '0 : mask_merged;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      mask_q      <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (store_we) begin
        fwd_valid_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_node_q     <= node_index_i;
      s1_nb_q       <= neighbor_index_i;
      s1_nb_valid_q <= neighbor_valid_i;
      s1_last_q     <= last_neighbor_i;
    end
    if (store_we) begin
      fwd_addr_q  <= s1_node_addr;
      fwd_color_q <= chosen;
    end
    if (out_load) begin
      colored_node_q <= s1_node_q;
      node_color_q   <= chosen;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign colored_node_o = colored_node_q;
  assign node_color_o   = node_color_q;

endmodule

@@ tb/greedy_first_fit_node_coloring_tb.sv @@
// Testbench for the greedy first-fit node coloring block: directed and random graphs.
module greedy_first_fit_node_coloring_tb;

  localparam int NW        = gfc_pkg::NodeW;
  localparam int CW        = gfc_pkg::ColorW;
  localparam int NodeMax   = (1 << gfc_pkg::NodeW) - 1;
  localparam int HoldBeats = 300;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [CW-1:0] color;
  } coloring_t;

  logic          clk_i            = 1'b0;
  logic          rst_ni           = 1'b0;
  logic          in_valid_i       = 1'b0;
  logic          in_stall_o;
  logic [NW-1:0] node_index_i     = '0;
  logic [NW-1:0] neighbor_index_i = '0;
  logic          neighbor_valid_i = 1'b0;
  logic          last_neighbor_i  = 1'b0;
  logic          out_valid_o;
  logic          out_stall_i      = 1'b0;
  logic [NW-1:0] colored_node_o;
  logic [CW-1:0] node_color_o;

  greedy_first_fit_node_coloring dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .node_index_i     (node_index_i),
    .neighbor_index_i (neighbor_index_i),
    .neighbor_valid_i (neighbor_valid_i),
    .last_neighbor_i  (last_neighbor_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .colored_node_o   (colored_node_o),
    .node_color_o     (node_color_o)
  );

  // Predictor state: stored colors, which entries hold one, and the used-color mask
  logic [CW-1:0]                  node_colors [gfc_pkg::MaxNodesDef];
  bit                             color_written [gfc_pkg::MaxNodesDef];
  int unsigned                    written_nodes_q[$];
  logic [gfc_pkg::MaskColors-1:0] used_colors = '0;
  coloring_t                      pending_colors_q[$];

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int err_cnt      = 0;
  int beats_sent   = 0;
  int colors_seen  = 0;
  int graph_runs   = 0;
  int max_color    = 0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Fold one accepted beat into the predicted state; queue a color on a node's last beat
  task automatic predict_coloring(input logic [NW-1:0] node, input logic [NW-1:0] nb,
                                  input logic nb_valid, input logic is_last);
    logic [CW-1:0] pick;
    coloring_t     exp_col;
    pick = '0;
    if (nb_valid && nb < node && int'(nb) < int'(gfc_pkg::MaxNodesDef)) begin
      if (int'(node_colors[nb]) < int'(gfc_pkg::MaskColors)) begin
        used_colors[node_colors[nb]] = 1'b1;
      end
    end
    if (is_last) begin
      while (int'(pick) < int'(gfc_pkg::ColorLimitDef) - 1 &&
             int'(pick) < int'(gfc_pkg::MaskColors) && used_colors[pick])
        pick++;
      if (int'(node) < int'(gfc_pkg::MaxNodesDef)) begin
        node_colors[node] = pick;
        if (!color_written[node]) begin
          written_nodes_q.insert(written_nodes_q.size(), 32'(node));
        end
        color_written[node] = 1'b1;
      end
      used_colors = '0;
      exp_col.node  = node;
      exp_col.color = pick;
      pending_colors_q.insert(pending_colors_q.size(), exp_col);
    end
  endtask

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input int unsigned node, input int unsigned nb, input bit nb_valid,
                           input bit is_last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    node_index_i     <= node[NW-1:0];
    neighbor_index_i <= nb[NW-1:0];
    neighbor_valid_i <= nb_valid;
    last_neighbor_i  <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    predict_coloring(node[NW-1:0], nb[NW-1:0], nb_valid, is_last);
    beats_sent++;
  endtask

  // Receiver: random stalls, or a long hold when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check each result beat against the oldest predicted color
  always @(posedge clk_i) begin
    coloring_t exp_col;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_colors_q.size() == 0) begin
        $error("result beat with no color pending: node %0d color %0d",
               colored_node_o, node_color_o);
        err_cnt++;
      end else begin
        exp_col = pending_colors_q.pop_front();
        if (colored_node_o !== exp_col.node) begin
          $error("colored_node mismatch: expected %0d, got %0d", exp_col.node, colored_node_o);
          err_cnt++;
        end
        if (node_color_o !== exp_col.color) begin
          $error("node_color mismatch: expected %0d, got %0d", exp_col.color, node_color_o);
          err_cnt++;
        end
        colors_seen++;
        if (int'(exp_col.color) > max_color) max_color = int'(exp_col.color);
      end
    end
  end

  // Small hand-built graph: every edge kind, mask carry-over and back-to-back reuse
  task automatic test_directed_cases();
    send_beat(0, NodeMax, 1'b0, 1'b1);      // isolated node
    send_beat(1, 0, 1'b1, 1'b1);
    send_beat(2, 0, 1'b1, 1'b0);
    send_beat(2, 1, 1'b1, 1'b1);
    send_beat(3, 3, 1'b1, 1'b0);            // self edge
    send_beat(3, NodeMax, 1'b1, 1'b0);      // higher neighbor
    send_beat(3, 0, 1'b0, 1'b0);            // no edge on this beat
    send_beat(3, 2, 1'b1, 1'b1);
    send_beat(4, 0, 1'b1, 1'b0);            // node ends without a last beat
    send_beat(5, 1, 1'b1, 1'b1);
    send_beat(6, 0, 1'b1, 1'b0);            // same neighbor twice
    send_beat(6, 0, 1'b1, 1'b1);
    send_beat(7, 1, 1'b1, 1'b0);
    send_beat(7, 0, 1'b0, 1'b1);            // last beat with no edge
    send_beat(8, 0, 1'b1, 1'b1);
    send_beat(9, 8, 1'b1, 1'b1);            // neighbor colored on the previous beat
    send_beat(10, 9, 1'b1, 1'b0);
    send_beat(10, 8, 1'b1, 1'b1);
    send_beat(NodeMax, 0, 1'b1, 1'b0);
    send_beat(NodeMax, NodeMax, 1'b1, 1'b1);
    send_beat(NodeMax - 1, NodeMax, 1'b1, 1'b1);
    send_beat(0, NodeMax, 1'b1, 1'b1);      // index drops: a new graph run
    graph_runs += 2;
  endtask

  // Clique larger than the color limit, so the top nodes hit the cap
  task automatic test_color_cap();
    int unsigned base;
    int unsigned off;
    base = $urandom_range(16, NodeMax - 20);
    send_beat(base, $urandom, 1'b0, 1'b1);
    for (int k = 1; k < 18; k++) begin
      off = $urandom_range(0, k - 1);
      for (int j = 0; j < k; j++)
        send_beat(base + k, base + (j + off) % k, 1'b1, j == k - 1);
    end
    graph_runs++;
  endtask

  // Random graph runs: non-decreasing nodes, mostly edges to nodes colored earlier in the run
  task automatic test_random_passes(input int n_beats);
    int          sent;
    int          node;
    int          run_len;
    int          deg;
    int          r;
    int          lo;
    int unsigned nb;
    bit          nb_valid;
    bit          ends;
    int unsigned run_q[$];
    sent = 0;
    while (sent < n_beats) begin
      node    = $urandom_range(0, NodeMax);
      run_len = $urandom_range(6, 60);
      run_q.delete();
      graph_runs++;
      for (int n = 0; n < run_len && node <= NodeMax && sent < n_beats; n++) begin
        r = $urandom_range(99);
        if (r < 10)      deg = 0;
        else if (r < 70) deg = $urandom_range(1, 4);
        else if (r < 95) deg = $urandom_range(5, 16);
        else             deg = $urandom_range(17, 24);
        ends = ($urandom_range(99) >= 8);
        if (deg == 0) begin
          send_beat(node, $urandom, 1'b0, ends);
          sent++;
        end
        for (int k = 0; k < deg; k++) begin
          r = $urandom_range(99);
          nb_valid = 1'b1;
          if (r < 70 && run_q.size() > 0) begin
            lo = (run_q.size() > 20) ? run_q.size() - 20 : 0;
            nb = run_q[$urandom_range(lo, run_q.size() - 1)];
          end else if (r < 78 && written_nodes_q.size() > 0) begin
            // earlier entries are safe to read; later ones add nothing
            nb = written_nodes_q[$urandom_range(0, written_nodes_q.size() - 1)];
          end else if (r < 90 || run_q.size() == 0) begin
            nb = $urandom_range(node, NodeMax);
          end else begin
            nb       = $urandom;
            nb_valid = 1'b0;
          end
          send_beat(node, nb, nb_valid, ends && k == deg - 1);
          sent++;
        end
        if (ends) run_q.insert(run_q.size(), node);
        node += $urandom_range(0, 3);
      end
    end
  endtask

  // Hold the result side for a long stretch while beats keep coming
  task automatic test_stalled_output();
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_left    = HoldBeats;
    test_random_passes(90);
  endtask

  // Stimulus sequence
  initial begin
    int wait_cnt;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_color_cap();

    send_gap_pct = 0;  stall_pct = 0;
    test_random_passes(375);
    send_gap_pct = 45; stall_pct = 0;
    test_random_passes(375);
    send_gap_pct = 0;  stall_pct = 45;
    test_random_passes(375);
    send_gap_pct = 35; stall_pct = 35;
    test_random_passes(375);

    test_stalled_output();

    // Drain outstanding colors, then let the pipeline settle
    in_valid_i <= 1'b0;
    stall_pct = 20;
    wait_cnt  = 0;
    while (pending_colors_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_colors_q.size() != 0) begin
      $error("%0d colors never arrived", pending_colors_q.size());
      err_cnt++;
    end

    $display("Sent %0d beats over %0d graph runs; checked %0d colors, highest %0d.",
             beats_sent, graph_runs, colors_seen, max_color);
    $display("Covered no idling, sender gaps, receiver stalls, both, and a %0d-cycle hold.",
             HoldBeats);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
